FILE: rtl/vpts_pkg.sv
// Shared types, constants and helpers for the vertex projection pipeline.
package vpts_pkg;

    // Fixed-point format of vertices, matrix entries and screen results
    localparam int FRAC_BITS = 16;

    // Quotient bits produced by the divider; normalized values clamp at 2^34
    localparam int DIV_BITS = 35;
    localparam int DW       = 32 + FRAC_BITS;
    localparam int HI_W     = DW - DIV_BITS;
    localparam int NDC_W    = DIV_BITS + 1;

    localparam logic signed [31:0] THRESH = 32'sd2 ** FRAC_BITS / 32'sd1000;
    localparam logic signed [NDC_W-1:0] ONE_NDC = NDC_W'(1) << FRAC_BITS;
    localparam logic [DIV_BITS-1:0] NDC_LIMIT = DIV_BITS'(1) << (DIV_BITS - 1);

    // Sentinel for culled vertices, -9999.0 saturated to 32 bits
    localparam logic signed [63:0] CULL_WIDE = -64'sd9999 * (64'sd1 <<< FRAC_BITS);
    localparam logic signed [31:0] CULL_VALUE =
        (CULL_WIDE < -64'sd2147483648) ? 32'sh8000_0000 : CULL_WIDE[31:0];

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ROW0_XY = 3'd0,
        REG_ROW0_ZT = 3'd1,
        REG_ROW1_XY = 3'd2,
        REG_ROW1_ZT = 3'd3,
        REG_ROWW_XY = 3'd4,
        REG_ROWW_ZT = 3'd5,
        REG_WIDTH   = 3'd6,
        REG_HEIGHT  = 3'd7
    } reg_idx_t;

    localparam logic [63:0] RST_ROW0_XY = 64'd65536;
    localparam logic [63:0] RST_ROW0_ZT = 64'd0;
    localparam logic [63:0] RST_ROW1_XY = 64'd281474976710656;
    localparam logic [63:0] RST_ROW1_ZT = 64'd0;
    localparam logic [63:0] RST_ROWW_XY = 64'd0;
    localparam logic [63:0] RST_ROWW_ZT = 64'd281474976710656;
    localparam logic [14:0] RST_WIDTH   = 15'd800;
    localparam logic [14:0] RST_HEIGHT  = 15'd600;

    // Decoded configuration as seen by the datapath
    typedef struct packed {
        logic signed [31:0] m00, m01, m02, m03;
        logic signed [31:0] m10, m11, m12, m13;
        logic signed [31:0] m30, m31, m32, m33;
        logic [14:0]        width;
        logic [14:0]        height;
    } cfg_t;

    // Clip-space coordinates
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cw;
    } clip_word_t;

    // One lane of the restoring divider
    typedef struct packed {
        logic                sign;
        logic                ovf;
        logic [30:0]         rem;
        logic [DIV_BITS-1:0] quo;
        logic [DIV_BITS-1:0] dvd;
    } div_lane_t;

    typedef struct packed {
        logic        vis;
        logic [30:0] w;
        div_lane_t   lx;
        div_lane_t   ly;
    } div_word_t;

    // Saturate to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/vpts_vertex_if.sv
// Vertex input channel.
interface vpts_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    output ready);
endinterface

FILE: rtl/vpts_screen_if.sv
// Screen result channel.
interface vpts_screen_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               visible;

    modport source (output valid, output screen_x, output screen_y, output visible,
                    input ready);
    modport sink   (input valid, input screen_x, input screen_y, input visible,
                    output ready);
endinterface

FILE: rtl/vpts_clip.sv
// Matrix rows 0, 1 and 3 times the vertex: products, then sum and saturate.
module vpts_clip (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vpts_pkg::cfg_t         cfg,
    vpts_vertex_if.sink            vtx,
    output logic                   clip_valid,
    input  logic                   clip_ready,
    output vpts_pkg::clip_word_t   clip_word
);

    logic               v0_reg, v1_reg;
    logic               adv0, adv1;
    logic signed [63:0] prod_reg [9];
    logic signed [31:0] t0_reg, t1_reg, t3_reg;
    vpts_pkg::clip_word_t clip_reg;

    logic signed [63:0] sum_x, sum_y, sum_w;

    // stall chain
    assign adv1      = !v1_reg || clip_ready;
    assign adv0      = !v0_reg || adv1;
    assign vtx.ready = adv0;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
                v0_reg <= vtx.valid;
            if (adv1)
                v1_reg <= v0_reg;
        end
    end

    // stage 0: nine products
    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            prod_reg[0] <= cfg.m00 * vtx.vertex_x;
            prod_reg[1] <= cfg.m01 * vtx.vertex_y;
            prod_reg[2] <= cfg.m02 * vtx.vertex_z;
            prod_reg[3] <= cfg.m10 * vtx.vertex_x;
            prod_reg[4] <= cfg.m11 * vtx.vertex_y;
            prod_reg[5] <= cfg.m12 * vtx.vertex_z;
            prod_reg[6] <= cfg.m30 * vtx.vertex_x;
            prod_reg[7] <= cfg.m31 * vtx.vertex_y;
            prod_reg[8] <= cfg.m32 * vtx.vertex_z;
            t0_reg      <= cfg.m03;
            t1_reg      <= cfg.m13;
            t3_reg      <= cfg.m33;
        end
    end

    // stage 1: floor shift, add translation, saturate
    always_comb
    begin
        sum_x = (prod_reg[0] >>> vpts_pkg::FRAC_BITS) + (prod_reg[1] >>> vpts_pkg::FRAC_BITS)
              + (prod_reg[2] >>> vpts_pkg::FRAC_BITS) + 64'(t0_reg);
        sum_y = (prod_reg[3] >>> vpts_pkg::FRAC_BITS) + (prod_reg[4] >>> vpts_pkg::FRAC_BITS)
              + (prod_reg[5] >>> vpts_pkg::FRAC_BITS) + 64'(t1_reg);
        sum_w = (prod_reg[6] >>> vpts_pkg::FRAC_BITS) + (prod_reg[7] >>> vpts_pkg::FRAC_BITS)
              + (prod_reg[8] >>> vpts_pkg::FRAC_BITS) + 64'(t3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            clip_reg.cx <= vpts_pkg::sat32(sum_x);
            clip_reg.cy <= vpts_pkg::sat32(sum_y);
            clip_reg.cw <= vpts_pkg::sat32(sum_w);
        end
    end

    assign clip_valid = v1_reg;
    assign clip_word  = clip_reg;

endmodule

FILE: rtl/vpts_div.sv
// Pipelined restoring divider: |c| * 2^FRAC_BITS / w for x and y, one bit a stage.
module vpts_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  vpts_pkg::clip_word_t   in_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output vpts_pkg::div_word_t    out_word
);

    localparam int NST = vpts_pkg::DIV_BITS + 1;

    logic                v_reg  [NST];
    vpts_pkg::div_word_t st_reg [NST];
    logic [NST:0]        adv;
    vpts_pkg::div_word_t init_word;

    // Set up one lane: magnitude, overflow check, first partial remainder
    function automatic vpts_pkg::div_lane_t lane_init(input logic signed [31:0] c,
                                                      input logic [30:0] w);
        vpts_pkg::div_lane_t           l;
        logic [31:0]                   mag;
        logic [vpts_pkg::DW-1:0]       dvd;
        logic [vpts_pkg::HI_W-1:0]     hi;
        mag    = c[31] ? (32'd0 - c) : c;
        dvd    = {mag, {vpts_pkg::FRAC_BITS{1'b0}}};
        hi     = dvd[vpts_pkg::DW-1:vpts_pkg::DIV_BITS];
        l.sign = c[31];
        l.ovf  = (32'(hi) >= {1'b0, w});
        l.rem  = 31'(hi);
        l.quo  = '0;
        l.dvd  = dvd[vpts_pkg::DIV_BITS-1:0];
        return l;
    endfunction

    // One restoring step: bring in the next dividend bit, trial subtract
    function automatic vpts_pkg::div_lane_t lane_step(input vpts_pkg::div_lane_t l,
                                                      input logic [30:0] w);
        vpts_pkg::div_lane_t n;
        logic [31:0]         r2;
        logic [31:0]         wx;
        n  = l;
        r2 = {l.rem, l.dvd[vpts_pkg::DIV_BITS-1]};
        wx = {1'b0, w};
        n.dvd = {l.dvd[vpts_pkg::DIV_BITS-2:0], 1'b0};
        if (r2 >= wx)
        begin
            n.rem = 31'(r2 - wx);
            n.quo = {l.quo[vpts_pkg::DIV_BITS-2:0], 1'b1};
        end
        else
        begin
            n.rem = r2[30:0];
            n.quo = {l.quo[vpts_pkg::DIV_BITS-2:0], 1'b0};
        end
        return n;
    endfunction

    // stall chain
    always_comb
    begin
        adv[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    assign in_ready = adv[0];

    always_comb
    begin
        init_word.vis = (in_word.cw > vpts_pkg::THRESH);
        init_word.w   = in_word.cw[30:0];
        init_word.lx  = lane_init(in_word.cx, in_word.cw[30:0]);
        init_word.ly  = lane_init(in_word.cy, in_word.cw[30:0]);
    end

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv[0])
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            st_reg[0] <= init_word;
    end

    // one quotient bit per stage
    for (genvar k = 1; k < NST; k++)
    begin : g_stage
        vpts_pkg::div_word_t step_next;

        always_comb
        begin
            step_next    = st_reg[k-1];
            step_next.lx = lane_step(st_reg[k-1].lx, st_reg[k-1].w);
            step_next.ly = lane_step(st_reg[k-1].ly, st_reg[k-1].w);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv[k])
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
                st_reg[k] <= step_next;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_word  = st_reg[NST-1];

endmodule

FILE: rtl/vpts_map.sv
// Viewport mapping: clamp and sign the quotients, scale by the viewport, saturate.
module vpts_map (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [14:0]            width,
    input  logic [14:0]            height,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  vpts_pkg::div_word_t    in_word,
    vpts_screen_if.source          scr
);

    localparam int NW = vpts_pkg::NDC_W;

    logic v0_reg, v1_reg, v2_reg;
    logic adv0, adv1, adv2;

    logic                    vis0_reg, vis1_reg, vis2_reg;
    logic signed [NW-1:0]    ax_reg, ay_reg;
    logic signed [NW+15:0]   px_reg, py_reg;
    logic signed [31:0]      sx_reg, sy_reg;
    logic signed [NW-1:0]    nx, ny;
    logic signed [63:0]      hx, hy;

    // Clamp the quotient magnitude and apply the sign
    function automatic logic signed [NW-1:0] ndc(input vpts_pkg::div_lane_t l);
        logic [vpts_pkg::DIV_BITS-1:0] mag;
        logic signed [NW-1:0]          n;
        mag = (l.ovf || l.quo[vpts_pkg::DIV_BITS-1]) ? vpts_pkg::NDC_LIMIT : l.quo;
        n   = l.sign ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        return n;
    endfunction

    // stall chain
    assign adv2     = !v2_reg || scr.ready;
    assign adv1     = !v1_reg || adv2;
    assign adv0     = !v0_reg || adv1;
    assign in_ready = adv0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
                v0_reg <= in_valid;
            if (adv1)
                v1_reg <= v0_reg;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    // stage 0: normalized coordinates offset by one
    always_comb
    begin
        nx = ndc(in_word.lx);
        ny = ndc(in_word.ly);
    end

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            ax_reg   <= nx + vpts_pkg::ONE_NDC;
            ay_reg   <= vpts_pkg::ONE_NDC - ny;
            vis0_reg <= in_word.vis;
        end
    end

    // stage 1: scale by viewport size
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            px_reg   <= ax_reg * $signed({1'b0, width});
            py_reg   <= ay_reg * $signed({1'b0, height});
            vis1_reg <= vis0_reg;
        end
    end

    // stage 2: halve, saturate, select the culled sentinel
    always_comb
    begin
        hx = 64'(px_reg >>> 1);
        hy = 64'(py_reg >>> 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            sx_reg   <= vis1_reg ? vpts_pkg::sat32(hx) : vpts_pkg::CULL_VALUE;
            sy_reg   <= vis1_reg ? vpts_pkg::sat32(hy) : vpts_pkg::CULL_VALUE;
            vis2_reg <= vis1_reg;
        end
    end

    assign scr.valid    = v2_reg;
    assign scr.screen_x = sx_reg;
    assign scr.screen_y = sy_reg;
    assign scr.visible  = vis2_reg;

endmodule

FILE: rtl/vertex_project_to_screen_unit.sv
// Top level of the vertex projection unit: configuration registers and pipeline.
//
// Takes one Q16.16 vertex per clock unless stalled, and returns one screen word per vertex,
// in order. Accepted vertices pass through registered stages for the matrix products and
// their sum, then the divider (one entry stage plus one quotient bit per stage for the
// 35-bit clamped quotient), then viewport mapping. Every stage holds its own valid bit,
// so a stalled output only stops the stages behind it once they are full.
// Matrix and viewport registers should be written while the pipeline is empty.
module vertex_project_to_screen_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    vpts_vertex_if.sink   vtx,
    vpts_screen_if.source scr
);

    logic [63:0] row0_xy_reg, row0_zt_reg, row1_xy_reg, row1_zt_reg;
    logic [63:0] roww_xy_reg, roww_zt_reg;
    logic [14:0] width_reg, height_reg;

    vpts_pkg::cfg_t       cfg;
    logic                 clip_valid, clip_ready;
    vpts_pkg::clip_word_t clip_word;
    logic                 div_valid, div_ready;
    vpts_pkg::div_word_t  div_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_xy_reg <= vpts_pkg::RST_ROW0_XY;
            row0_zt_reg <= vpts_pkg::RST_ROW0_ZT;
            row1_xy_reg <= vpts_pkg::RST_ROW1_XY;
            row1_zt_reg <= vpts_pkg::RST_ROW1_ZT;
            roww_xy_reg <= vpts_pkg::RST_ROWW_XY;
            roww_zt_reg <= vpts_pkg::RST_ROWW_ZT;
            width_reg   <= vpts_pkg::RST_WIDTH;
            height_reg  <= vpts_pkg::RST_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (vpts_pkg::reg_idx_t'(cfg_index))
                vpts_pkg::REG_ROW0_XY: row0_xy_reg <= cfg_wdata;
                vpts_pkg::REG_ROW0_ZT: row0_zt_reg <= cfg_wdata;
                vpts_pkg::REG_ROW1_XY: row1_xy_reg <= cfg_wdata;
                vpts_pkg::REG_ROW1_ZT: row1_zt_reg <= cfg_wdata;
                vpts_pkg::REG_ROWW_XY: roww_xy_reg <= cfg_wdata;
                vpts_pkg::REG_ROWW_ZT: roww_zt_reg <= cfg_wdata;
                vpts_pkg::REG_WIDTH:   width_reg   <= cfg_wdata[14:0];
                vpts_pkg::REG_HEIGHT:  height_reg  <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // unpack matrix entries
    always_comb
    begin
        cfg.m00    = row0_xy_reg[31:0];
        cfg.m01    = row0_xy_reg[63:32];
        cfg.m02    = row0_zt_reg[31:0];
        cfg.m03    = row0_zt_reg[63:32];
        cfg.m10    = row1_xy_reg[31:0];
        cfg.m11    = row1_xy_reg[63:32];
        cfg.m12    = row1_zt_reg[31:0];
        cfg.m13    = row1_zt_reg[63:32];
        cfg.m30    = roww_xy_reg[31:0];
        cfg.m31    = roww_xy_reg[63:32];
        cfg.m32    = roww_zt_reg[31:0];
        cfg.m33    = roww_zt_reg[63:32];
        cfg.width  = width_reg;
        cfg.height = height_reg;
    end

    vpts_clip u_clip (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .vtx        (vtx),
        .clip_valid (clip_valid),
        .clip_ready (clip_ready),
        .clip_word  (clip_word)
    );

    vpts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (clip_valid),
        .in_ready  (clip_ready),
        .in_word   (clip_word),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_word  (div_word)
    );

    vpts_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .width    (cfg.width),
        .height   (cfg.height),
        .in_valid (div_valid),
        .in_ready (div_ready),
        .in_word  (div_word),
        .scr      (scr)
    );

`ifndef SYNTHESIS
    // culled words carry the sentinel on both coordinates
    a_cull_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        scr.valid && !scr.visible |->
            scr.screen_x == vpts_pkg::CULL_VALUE && scr.screen_y == vpts_pkg::CULL_VALUE)
        else $error("culled word without sentinel");

    // a clip word blocked by the divider is not dropped
    a_clip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && !clip_ready |=> clip_valid && $stable(clip_word))
        else $error("clip word lost under stall");

    // divider output blocked by mapping is held
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid && !div_ready |=> div_valid && $stable(div_word))
        else $error("divider word lost under stall");
`endif

endmodule
